// ===== src/tpi_pkg.sv =====
// ----------------------------------------------------------------------------
// Turtle path interpreter package
// Shared widths, reset values, command codes and handoff types.
// ----------------------------------------------------------------------------
package tpi_pkg;

    localparam int STACK_DEPTH_DEF  = 256;
    localparam int SINE_ENTRIES_DEF = 1024;

    localparam int POS_W  = 24;
    localparam int HEAD_W = 16;
    localparam int LEN_W  = 16;
    localparam int SYM_W  = 8;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 24;

    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = -24'sh800000;

    localparam logic signed [POS_W-1:0] START_X_RST   = 24'sd102400;
    localparam logic signed [POS_W-1:0] START_Y_RST   = 24'sd145920;
    localparam logic [HEAD_W-1:0]       HEADING_RST   = 16'd16384;
    localparam logic [LEN_W-1:0]        STEP_LEN_RST  = 16'd1792;
    localparam logic [HEAD_W-1:0]       TURN_STEP_RST = 16'd4551;

    localparam logic [HEAD_W-1:0] QUARTER_TURN = 16'd16384;

    localparam logic [SYM_W-1:0] SYM_MOVE  = 8'h46;  // F
    localparam logic [SYM_W-1:0] SYM_LEFT  = 8'h2B;  // +
    localparam logic [SYM_W-1:0] SYM_RIGHT = 8'h2D;  // -
    localparam logic [SYM_W-1:0] SYM_PUSH  = 8'h5B;  // [
    localparam logic [SYM_W-1:0] SYM_POP   = 8'h5D;  // ]

    typedef enum logic [CFG_AW-1:0] {
        CFG_START_X   = 3'd0,
        CFG_START_Y   = 3'd1,
        CFG_HEADING   = 3'd2,
        CFG_STEP_LEN  = 3'd3,
        CFG_TURN_STEP = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MOVE,
        OP_LEFT,
        OP_RIGHT,
        OP_PUSH,
        OP_POP
    } op_t;

    typedef enum logic [1:0] {
        ST_DRAWN     = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        EX_RUN,
        EX_MOVE,
        EX_POP
    } ex_state_t;

    typedef struct packed {
        op_t  op;
        logic first;
    } cmd_t;

    typedef struct packed {
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic [HEAD_W-1:0]       heading;
        logic [LEN_W-1:0]        step_len;
        logic [HEAD_W-1:0]       turn_step;
    } cfg_t;

endpackage

// ===== src/tpi_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tpi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/tpi_sine_rom.sv =====
// ----------------------------------------------------------------------------
// Quarter-wave sine ROM
// Entry k holds sin(pi/2 * k / ENTRIES) scaled to 32768, built at elaboration
// from an integer Taylor series. Registered read with enable.
// ----------------------------------------------------------------------------
module tpi_sine_rom #(
    parameter int ENTRIES = 1024
) (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [$clog2(ENTRIES+1)-1:0] rd_addr,
    output logic [15:0]                  rd_data
);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [15:0] rom_t [0:ENTRIES];

    function automatic rom_t build_rom();
        rom_t               t;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        for (int k = 0; k <= ENTRIES; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) / 64'(ENTRIES);
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            v = (($unsigned(sum) * 64'd32768) + (64'd1 << 29)) >> 30;
            if (v > 64'd32768) begin
                v = 64'd32768;
            end
            t[k] = v[15:0];
        end
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ROM[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/tpi_front.sv =====
// ----------------------------------------------------------------------------
// Turtle path interpreter front end
// Accepts symbol words, decodes them into commands and queues them for the
// execution stage in a two-entry queue.
// ----------------------------------------------------------------------------
module tpi_front
    import tpi_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [SYM_W-1:0] s_tdata,   // [7:0] symbol
    input  logic [0:0]       s_tuser,   // [0] first_of_string
    output logic             q_valid,
    output cmd_t             q_cmd,
    input  logic             q_pop
);

    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    cmd_t             q_mem_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    cmd_t             cmd_in;

    function automatic op_t decode(input logic [SYM_W-1:0] sym);
        op_t op;
        unique case (sym)
            SYM_MOVE:  op = OP_MOVE;
            SYM_LEFT:  op = OP_LEFT;
            SYM_RIGHT: op = OP_RIGHT;
            SYM_PUSH:  op = OP_PUSH;
            SYM_POP:   op = OP_POP;
            default:   op = OP_NONE;
        endcase
        return op;
    endfunction

    assign s_tready     = (count_reg != CNT_W'(Q_DEPTH));
    assign push         = s_tvalid && s_tready;
    assign cmd_in.op    = decode(s_tdata);
    assign cmd_in.first = s_tuser[0];
    assign q_valid      = (count_reg != '0);
    assign q_cmd        = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (!push && q_pop) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== src/tpi_back.sv =====
// ----------------------------------------------------------------------------
// Turtle path interpreter execution stage
// Holds the turtle state, walks the sine ROMs and the save stack, and drives
// the segment output register.
// ----------------------------------------------------------------------------
module tpi_back
    import tpi_pkg::*;
#(
    parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 q_valid,
    input  cmd_t                 q_cmd,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [4*POS_W-1:0]   m_tdata,
    output logic [1:0]           m_tuser
);

    localparam int LVL_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int IDX_W   = $clog2(SINE_ENTRIES + 1);
    localparam int PROD_W  = 15 + IDX_W;
    localparam int ENTRY_W = 2 * POS_W + HEAD_W;
    localparam int MUL_W   = 34;
    localparam int DEL_W   = MUL_W - 15;
    localparam int SUM_W   = POS_W + 2;

    ex_state_t state_reg, state_next;

    logic signed [POS_W-1:0] pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0] pos_y_reg, pos_y_next;
    logic [HEAD_W-1:0]       heading_reg, heading_next;
    logic [LVL_W-1:0]        level_reg, level_next;
    logic                    sin_neg_reg, sin_neg_next;
    logic                    cos_neg_reg, cos_neg_next;

    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic signed [POS_W-1:0] from_x_reg, from_x_next;
    logic signed [POS_W-1:0] from_y_reg, from_y_next;
    logic signed [POS_W-1:0] to_x_reg, to_x_next;
    logic signed [POS_W-1:0] to_y_reg, to_y_next;

    logic                    out_free;
    logic                    take;
    logic signed [POS_W-1:0] x_eff, y_eff;
    logic [HEAD_W-1:0]       h_eff, h_cos;
    logic [LVL_W-1:0]        lvl_eff, lvl_dec;

    logic                    rom_en;
    logic [IDX_W-1:0]        sin_idx, cos_idx;
    logic                    sin_neg_now, cos_neg_now;
    logic [15:0]             sin_mag, cos_mag;

    logic                    ram_we, ram_re;
    logic [ENTRY_W-1:0]      ram_rdata;

    logic signed [16:0]      sin_trig, cos_trig;
    logic signed [MUL_W-1:0] sin_prod, cos_prod;
    logic signed [DEL_W-1:0] dx, dy;
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic signed [POS_W-1:0] new_x, new_y;

    // quarter-wave lookup: mirror the phase in odd quadrants, negate in the
    // lower half turn
    function automatic logic [IDX_W-1:0] wave_index(input logic [HEAD_W-1:0] h);
        logic [14:0]       ph;
        logic [PROD_W-1:0] prod;
        ph   = h[14] ? (15'd16384 - {1'b0, h[13:0]}) : {1'b0, h[13:0]};
        prod = PROD_W'(ph) * PROD_W'(SINE_ENTRIES);
        return prod[14 +: IDX_W];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > SUM_W'(POS_MAX)) begin
            r = POS_MAX;
        end else if (v < SUM_W'(POS_MIN)) begin
            r = POS_MIN;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    assign out_free = !out_valid_reg || m_tready;
    assign take     = (state_reg == EX_RUN) && q_valid && out_free;
    assign q_pop    = take;

    // a first symbol restarts the turtle before it acts
    assign x_eff   = q_cmd.first ? cfg.start_x : pos_x_reg;
    assign y_eff   = q_cmd.first ? cfg.start_y : pos_y_reg;
    assign h_eff   = q_cmd.first ? cfg.heading : heading_reg;
    assign lvl_eff = q_cmd.first ? '0 : level_reg;
    assign lvl_dec = LVL_W'(lvl_eff - 1'b1);
    assign h_cos   = HEAD_W'(h_eff + QUARTER_TURN);

    assign sin_idx     = wave_index(h_eff);
    assign cos_idx     = wave_index(h_cos);
    assign sin_neg_now = h_eff[15];
    assign cos_neg_now = h_cos[15];

    assign rom_en = take && (q_cmd.op == OP_MOVE);
    assign ram_we = take && (q_cmd.op == OP_PUSH) && (lvl_eff != LVL_W'(STACK_DEPTH));
    assign ram_re = take && (q_cmd.op == OP_POP) && (lvl_eff != '0);

    tpi_sine_rom #(.ENTRIES(SINE_ENTRIES)) u_sin_rom (
        .aclk    (aclk),
        .rd_en   (rom_en),
        .rd_addr (sin_idx),
        .rd_data (sin_mag)
    );

    tpi_sine_rom #(.ENTRIES(SINE_ENTRIES)) u_cos_rom (
        .aclk    (aclk),
        .rd_en   (rom_en),
        .rd_addr (cos_idx),
        .rd_data (cos_mag)
    );

    tpi_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (lvl_eff[ADDR_W-1:0]),
        .wr_data ({x_eff, y_eff, h_eff}),
        .rd_en   (ram_re),
        .rd_addr (lvl_dec[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    // move arithmetic: scale, round to Q16.8, add and saturate
    assign sin_trig = sin_neg_reg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    assign cos_trig = cos_neg_reg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
    assign sin_prod = MUL_W'(sin_trig) * MUL_W'($signed({1'b0, cfg.step_len}));
    assign cos_prod = MUL_W'(cos_trig) * MUL_W'($signed({1'b0, cfg.step_len}));
    assign dx       = DEL_W'((cos_prod + MUL_W'(16384)) >>> 15);
    assign dy       = DEL_W'((sin_prod + MUL_W'(16384)) >>> 15);
    assign sum_x    = SUM_W'(pos_x_reg) + SUM_W'(dx);
    assign sum_y    = SUM_W'(pos_y_reg) - SUM_W'(dy);
    assign new_x    = sat_pos(sum_x);
    assign new_y    = sat_pos(sum_y);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            EX_RUN: begin
                if (rom_en) begin
                    state_next = EX_MOVE;
                end else if (ram_re) begin
                    state_next = EX_POP;
                end
            end
            EX_MOVE: state_next = EX_RUN;
            EX_POP:  state_next = EX_RUN;
            default: state_next = EX_RUN;
        endcase
    end

    // turtle state and result word
    always_comb begin
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        heading_next    = heading_reg;
        level_next      = level_reg;
        sin_neg_next    = sin_neg_reg;
        cos_neg_next    = cos_neg_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        from_x_next     = from_x_reg;
        from_y_next     = from_y_reg;
        to_x_next       = to_x_reg;
        to_y_next       = to_y_reg;

        unique case (state_reg)
            EX_RUN: begin
                if (take) begin
                    pos_x_next   = x_eff;
                    pos_y_next   = y_eff;
                    heading_next = h_eff;
                    level_next   = lvl_eff;
                    unique case (q_cmd.op)
                        OP_MOVE: begin
                            sin_neg_next = sin_neg_now;
                            cos_neg_next = cos_neg_now;
                        end
                        OP_LEFT:  heading_next = HEAD_W'(h_eff + cfg.turn_step);
                        OP_RIGHT: heading_next = HEAD_W'(h_eff - cfg.turn_step);
                        OP_PUSH: begin
                            if (ram_we) begin
                                level_next = LVL_W'(lvl_eff + 1'b1);
                            end else begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_OVERFLOW;
                                from_x_next     = x_eff;
                                from_y_next     = y_eff;
                                to_x_next       = x_eff;
                                to_y_next       = y_eff;
                            end
                        end
                        OP_POP: begin
                            if (ram_re) begin
                                level_next = lvl_dec;
                            end else begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_UNDERFLOW;
                                from_x_next     = x_eff;
                                from_y_next     = y_eff;
                                to_x_next       = x_eff;
                                to_y_next       = y_eff;
                            end
                        end
                        OP_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            EX_MOVE: begin
                out_valid_next  = 1'b1;
                out_status_next = ST_DRAWN;
                from_x_next     = pos_x_reg;
                from_y_next     = pos_y_reg;
                to_x_next       = new_x;
                to_y_next       = new_y;
                pos_x_next      = new_x;
                pos_y_next      = new_y;
            end
            EX_POP: begin
                pos_x_next   = ram_rdata[ENTRY_W-1 -: POS_W];
                pos_y_next   = ram_rdata[HEAD_W +: POS_W];
                heading_next = ram_rdata[HEAD_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= EX_RUN;
            pos_x_reg     <= START_X_RST;
            pos_y_reg     <= START_Y_RST;
            heading_reg   <= HEADING_RST;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            heading_reg   <= heading_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sin_neg_reg    <= sin_neg_next;
        cos_neg_reg    <= cos_neg_next;
        out_status_reg <= out_status_next;
        from_x_reg     <= from_x_next;
        from_y_reg     <= from_y_next;
        to_x_reg       <= to_x_next;
        to_y_reg       <= to_y_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {to_y_reg, to_x_reg, from_y_reg, from_x_reg};

    // stack level never passes the depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LVL_W'(STACK_DEPTH))
        else $error("stack level beyond depth");

    // EX_MOVE and EX_POP only follow an accepted command
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == EX_MOVE || state_reg == EX_POP) |-> $past(take))
        else $error("second cycle without a command");

    // output stage is empty whenever EX_MOVE or EX_POP runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != EX_RUN) |-> !out_valid_reg)
        else $error("result pending during second cycle");

    // no push and pop of the stack in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("stack write and read together");

endmodule

// ===== src/turtle_path_interpreter_top.sv =====
// ----------------------------------------------------------------------------
// Turtle path interpreter
// L-system turtle: symbol words in, line segments and stack errors out.
// ----------------------------------------------------------------------------
// Each symbol word is decoded in the front end and handed through a two-entry
// queue to the execution stage, so the input keeps taking words while a result
// waits at the output. An F move passes through EX_MOVE (registered sine and
// cosine ROM read, then scale, round and saturating add), and a successful pop
// through EX_POP (registered read of the save-stack RAM). A word with
// first_of_string set restarts position, heading and stack from the configured
// values before it acts. Stack entries are only read below the fill level, so
// the stack RAM needs no clearing after reset. The user must write
// configuration only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module turtle_path_interpreter_top
    import tpi_pkg::*;
#(
    parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CFG_AW-1:0]  cfg_wr_addr,
    input  logic [CFG_DW-1:0]  cfg_wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [SYM_W-1:0]   s_tdata,   // [7:0] symbol
    input  logic [0:0]         s_tuser,   // [0] first_of_string
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [4*POS_W-1:0] m_tdata,   // from_x, from_y, to_x, to_y (24 bits each)
    output logic [1:0]         m_tuser    // [1:0] status
);

    cfg_t cfg_reg, cfg_next;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_wr_addr))
                CFG_START_X:   cfg_next.start_x   = cfg_wr_data[POS_W-1:0];
                CFG_START_Y:   cfg_next.start_y   = cfg_wr_data[POS_W-1:0];
                CFG_HEADING:   cfg_next.heading   = cfg_wr_data[HEAD_W-1:0];
                CFG_STEP_LEN:  cfg_next.step_len  = cfg_wr_data[LEN_W-1:0];
                CFG_TURN_STEP: cfg_next.turn_step = cfg_wr_data[HEAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_x   <= START_X_RST;
            cfg_reg.start_y   <= START_Y_RST;
            cfg_reg.heading   <= HEADING_RST;
            cfg_reg.step_len  <= STEP_LEN_RST;
            cfg_reg.turn_step <= TURN_STEP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tpi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    tpi_back #(
        .STACK_DEPTH  (STACK_DEPTH),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== tb/turtle_segment_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turtle segment checker
// Tracks configuration writes and accepted symbol words and keeps its own
// turtle: position, heading and save stack. It predicts every segment and
// stack error, and compares each result word in order against the prediction.
// ----------------------------------------------------------------------------
module turtle_segment_checker
    import tpi_pkg::*;
#(
    parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CFG_AW-1:0]  cfg_wr_addr,
    input  logic [CFG_DW-1:0]  cfg_wr_data,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [SYM_W-1:0]   s_tdata,
    input  logic [0:0]         s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [4*POS_W-1:0] m_tdata,
    input  logic [1:0]         m_tuser,
    output int                 mismatch_count,
    output int                 segments_outstanding
);

    typedef longint unsigned u64_t;
    typedef logic signed [POS_W-1:0] pos_t;

    typedef struct {
        status_t status;
        pos_t    from_x;
        pos_t    from_y;
        pos_t    to_x;
        pos_t    to_y;
    } segment_t;

    typedef struct {
        pos_t              x;
        pos_t              y;
        logic [HEAD_W-1:0] heading;
    } pose_t;

    localparam u64_t HALF_PI_Q30   = 64'd1686629713;
    localparam int   TERMS         = 8;
    localparam int   MAX_REPORTS   = 10;
    localparam int   MOVE_FRAC     = 15;
    localparam int   MOVE_ROUNDING = 1 << (MOVE_FRAC - 1);

    logic [15:0] quarter_sine [0:SINE_ENTRIES];
    cfg_t        regs;
    pose_t       turtle;
    pose_t       saved_poses [STACK_DEPTH];
    int          stack_fill;
    segment_t    expected_segments [$];

    // Quarter-wave sine, 1.0 = 32768, from a truncating Q30 Taylor series.
    function automatic void build_quarter_sine();
        u64_t   x, x2, term, v;
        longint sum;
        for (int k = 0; k <= SINE_ENTRIES; k++) begin
            x    = HALF_PI_Q30 * u64_t'(k) / u64_t'(SINE_ENTRIES);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= TERMS; n++) begin
                term = ((term * x2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum -= longint'(term);
                end else begin
                    sum += longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (u64_t'(sum) * 32768 + (u64_t'(1) << 29)) >> 30;
            if (v > 32768) begin
                v = 32768;
            end
            quarter_sine[k] = v[15:0];
        end
    endfunction

    function automatic int sine_of(logic [HEAD_W-1:0] h);
        logic [1:0] quad;
        int         phase;
        int         mag;
        quad  = h[15:14];
        phase = int'(h[13:0]);
        // mirror the phase in the second and fourth quadrants
        if (quad[0]) begin
            phase = int'(QUARTER_TURN) - phase;
        end
        mag = int'(quarter_sine[phase * SINE_ENTRIES / int'(QUARTER_TURN)]);
        return quad[1] ? -mag : mag;
    endfunction

    function automatic longint move_delta(int trig);
        return (longint'(trig) * longint'(regs.step_len) + MOVE_ROUNDING) >>> MOVE_FRAC;
    endfunction

    function automatic pos_t clamp_pos(longint v);
        if (v > longint'(POS_MAX)) begin
            return POS_MAX;
        end
        if (v < longint'(POS_MIN)) begin
            return POS_MIN;
        end
        return pos_t'(v);
    endfunction

    function automatic void restart_turtle();
        turtle.x       = regs.start_x;
        turtle.y       = regs.start_y;
        turtle.heading = regs.heading;
        stack_fill     = 0;
    endfunction

    function automatic void interpret_symbol(logic [SYM_W-1:0] sym, logic first);
        segment_t seg;
        if (first) begin
            restart_turtle();
        end
        seg.from_x = turtle.x;
        seg.from_y = turtle.y;
        seg.to_x   = turtle.x;
        seg.to_y   = turtle.y;
        case (sym)
            SYM_MOVE: begin
                seg.status = ST_DRAWN;
                seg.to_x   = clamp_pos(longint'(turtle.x)
                                       + move_delta(sine_of(turtle.heading + QUARTER_TURN)));
                seg.to_y   = clamp_pos(longint'(turtle.y)
                                       - move_delta(sine_of(turtle.heading)));
                turtle.x   = seg.to_x;
                turtle.y   = seg.to_y;
                expected_segments.push_back(seg);
            end
            SYM_LEFT: begin
                turtle.heading = turtle.heading + regs.turn_step;
            end
            SYM_RIGHT: begin
                turtle.heading = turtle.heading - regs.turn_step;
            end
            SYM_PUSH: begin
                if (stack_fill >= STACK_DEPTH) begin
                    seg.status = ST_OVERFLOW;
                    expected_segments.push_back(seg);
                end else begin
                    saved_poses[stack_fill] = turtle;
                    stack_fill++;
                end
            end
            SYM_POP: begin
                if (stack_fill == 0) begin
                    seg.status = ST_UNDERFLOW;
                    expected_segments.push_back(seg);
                end else begin
                    stack_fill--;
                    turtle = saved_poses[stack_fill];
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void record_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    initial begin
        build_quarter_sine();
        mismatch_count       = 0;
        segments_outstanding = 0;
    end

    always @(posedge aclk) begin : watch
        segment_t want;
        segment_t got;
        if (!aresetn) begin
            regs.start_x   = START_X_RST;
            regs.start_y   = START_Y_RST;
            regs.heading   = HEADING_RST;
            regs.step_len  = STEP_LEN_RST;
            regs.turn_step = TURN_STEP_RST;
            restart_turtle();
            expected_segments.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser);
                got.from_x = m_tdata[POS_W-1:0];
                got.from_y = m_tdata[2*POS_W-1:POS_W];
                got.to_x   = m_tdata[3*POS_W-1:2*POS_W];
                got.to_y   = m_tdata[4*POS_W-1:3*POS_W];
                if (expected_segments.size() == 0) begin
                    record_failure($sformatf(
                        "unexpected word: status %0d from (%0d,%0d) to (%0d,%0d)",
                        got.status, got.from_x, got.from_y, got.to_x, got.to_y));
                end else begin
                    want = expected_segments.pop_front();
                    if (got.status !== want.status || got.from_x !== want.from_x ||
                        got.from_y !== want.from_y || got.to_x !== want.to_x ||
                        got.to_y !== want.to_y) begin
                        record_failure($sformatf(
                            {"mismatch: expected status %0d from (%0d,%0d) to (%0d,%0d),",
                             " got status %0d from (%0d,%0d) to (%0d,%0d)"},
                            want.status, want.from_x, want.from_y, want.to_x, want.to_y,
                            got.status, got.from_x, got.from_y, got.to_x, got.to_y));
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_wr_addr)
                    CFG_START_X:   regs.start_x   = cfg_wr_data[POS_W-1:0];
                    CFG_START_Y:   regs.start_y   = cfg_wr_data[POS_W-1:0];
                    CFG_HEADING:   regs.heading   = cfg_wr_data[HEAD_W-1:0];
                    CFG_STEP_LEN:  regs.step_len  = cfg_wr_data[LEN_W-1:0];
                    CFG_TURN_STEP: regs.turn_step = cfg_wr_data[HEAD_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                interpret_symbol(s_tdata, s_tuser[0]);
            end
        end
        segments_outstanding = expected_segments.size();
    end

endmodule

// ===== tb/tb_turtle_path_interpreter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turtle path interpreter testbench
// Drives symbol words in bursts against a stalling result receiver: a short
// directed run over every command, stack underflow and the position and
// register extremes, then random phases of L-system strings, broken strings
// and noise under changing configuration. A separate checker predicts and
// compares; this module only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_turtle_path_interpreter_top;
    import tpi_pkg::*;

    localparam int SYMBOL_TARGET = 1900;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [CFG_AW-1:0] CFG_FIRST_UNUSED = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_LAST_UNUSED  = 3'd7;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_CHOKE
    } rx_mode_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [CFG_AW-1:0]  cfg_wr_addr;
    logic [CFG_DW-1:0]  cfg_wr_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [SYM_W-1:0]   s_tdata;
    logic [0:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [4*POS_W-1:0] m_tdata;
    logic [1:0]         m_tuser;

    int mismatch_count;
    int segments_outstanding;
    int symbols_sent;
    int burst_left;
    int gap_limit;
    bit stack_filled;

    turtle_path_interpreter_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_addr (cfg_wr_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    turtle_segment_checker u_checker (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_addr          (cfg_wr_addr),
        .cfg_wr_data          (cfg_wr_data),
        .s_tvalid             (s_tvalid),
        .s_tready             (s_tready),
        .s_tdata              (s_tdata),
        .s_tuser              (s_tuser),
        .m_tvalid             (m_tvalid),
        .m_tready             (m_tready),
        .m_tdata              (m_tdata),
        .m_tuser              (m_tuser),
        .mismatch_count       (mismatch_count),
        .segments_outstanding (segments_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver: switch between stall patterns, each held for a random span.
    initial begin
        rx_mode_t mode;
        int       span;
        m_tready = 1'b0;
        forever begin
            mode = rx_mode_t'($urandom_range(RX_OPEN, RX_CHOKE));
            span = $urandom_range(16, 96);
            repeat (span) begin
                @(posedge aclk);
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic first);
        int   gap;
        logic took;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tuser  <= first;
        // tready is stable at the falling edge; it decides the next rising one
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        symbols_sent++;
    endtask

    task automatic drain_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(negedge aclk); while (segments_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic poke_register(input logic [CFG_AW-1:0] addr,
                                 input logic [CFG_DW-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_wr_addr <= addr;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    // Write all five registers, with junk above the 16-bit ones, plus one
    // write to an unmapped index.
    task automatic write_config(input logic [POS_W-1:0] sx, input logic [POS_W-1:0] sy,
                                input logic [HEAD_W-1:0] head,
                                input logic [LEN_W-1:0] len,
                                input logic [HEAD_W-1:0] turn);
        poke_register(CFG_START_X, sx);
        poke_register(CFG_START_Y, sy);
        poke_register(CFG_HEADING, {8'($urandom), head});
        poke_register(CFG_STEP_LEN, {8'($urandom), len});
        poke_register(CFG_TURN_STEP, {8'($urandom), turn});
        poke_register(CFG_AW'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                      24'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_config();
        logic [POS_W-1:0]  sx;
        logic [POS_W-1:0]  sy;
        logic [LEN_W-1:0]  len;
        logic [HEAD_W-1:0] turn;
        if ($urandom_range(0, 2) == 0) begin
            sx = 24'($urandom);
            sy = 24'($urandom);
        end else begin
            sx = 24'($urandom_range(0, 1 << 18) - (1 << 17));
            sy = 24'($urandom_range(0, 1 << 18) - (1 << 17));
        end
        case ($urandom_range(0, 3))
            0:       len = 16'($urandom_range(0, 1024));
            1:       len = 16'($urandom_range(1024, 8192));
            2:       len = 16'($urandom);
            default: len = 16'hFFFF;
        endcase
        case ($urandom_range(0, 3))
            0:       turn = TURN_STEP_RST;
            1:       turn = QUARTER_TURN;
            2:       turn = 16'($urandom);
            default: turn = 16'($urandom_range(0, 64));
        endcase
        write_config(sx, sy, 16'($urandom), len, turn);
    endtask

    function automatic logic [SYM_W-1:0] pick_command();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) return SYM_MOVE;
        if (roll < 6) return SYM_LEFT;
        if (roll < 8) return SYM_RIGHT;
        if (roll < 9) return SYM_PUSH;
        return SYM_POP;
    endfunction

    task automatic send_string();
        int               kind;
        int               len;
        int               open;
        logic [SYM_W-1:0] sym;
        kind = $urandom_range(0, 9);
        len  = $urandom_range(4, 30);
        open = 0;
        if (kind < 7) begin
            // well-formed string: brackets balanced, closed at the end
            for (int i = 0; i <= len; i++) begin
                sym = pick_command();
                if (sym == SYM_POP && open == 0) begin
                    sym = SYM_PUSH;
                end
                if (sym == SYM_PUSH) begin
                    open++;
                end else if (sym == SYM_POP) begin
                    open--;
                end
                send_symbol(sym, i == 0);
            end
            for (; open > 0; open--) begin
                send_symbol(SYM_POP, 1'b0);
            end
        end else if (kind < 9) begin
            // broken string: stray pops, unclosed pushes, odd restarts
            for (int i = 0; i < len; i++) begin
                send_symbol(pick_command(), $urandom_range(0, 9) == 0);
            end
        end else begin
            for (int i = 0; i < len; i++) begin
                send_symbol(8'($urandom), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    // Fill the save stack to the top, overflow it, then unwind past empty.
    task automatic fill_stack();
        send_symbol(SYM_PUSH, 1'b1);
        for (int i = 1; i < STACK_DEPTH_DEF + 2; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                send_symbol(pick_command() == SYM_MOVE ? SYM_MOVE : SYM_LEFT, 1'b0);
            end
            send_symbol(SYM_PUSH, 1'b0);
        end
        for (int i = 0; i < STACK_DEPTH_DEF + 1; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                send_symbol(SYM_MOVE, 1'b0);
            end
            send_symbol(SYM_POP, 1'b0);
        end
    endtask

    initial begin
        int phase_end;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_addr  = '0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        symbols_sent = 0;
        burst_left   = 0;
        gap_limit    = 3;
        stack_filled = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration: every command, underflow, ignored symbols
        send_symbol(SYM_POP, 1'b1);
        send_symbol(SYM_MOVE, 1'b0);
        send_symbol(SYM_LEFT, 1'b0);
        send_symbol(SYM_MOVE, 1'b0);
        send_symbol(SYM_RIGHT, 1'b0);
        send_symbol(SYM_RIGHT, 1'b0);
        send_symbol(SYM_MOVE, 1'b0);
        send_symbol(SYM_PUSH, 1'b0);
        send_symbol(SYM_MOVE, 1'b0);
        send_symbol(SYM_POP, 1'b0);
        send_symbol(SYM_MOVE, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b1);
        send_symbol(SYM_MOVE, 1'b0);
        drain_results();

        // largest step from corners: x saturates high, y goes up and back down
        write_config(POS_MAX, POS_MIN, 16'h0000, 16'hFFFF, QUARTER_TURN);
        send_symbol(SYM_MOVE, 1'b1);
        send_symbol(SYM_RIGHT, 1'b0);
        send_symbol(SYM_MOVE, 1'b0);
        send_symbol(SYM_LEFT, 1'b0);
        send_symbol(SYM_LEFT, 1'b0);
        send_symbol(SYM_MOVE, 1'b0);
        drain_results();

        // zero step, full turn step, heading at the top of its range
        write_config(POS_MIN, POS_MAX, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_symbol(SYM_MOVE, 1'b1);
        send_symbol(SYM_LEFT, 1'b0);
        send_symbol(SYM_MOVE, 1'b0);

        while (symbols_sent < SYMBOL_TARGET) begin
            drain_results();
            random_config();
            case ($urandom_range(0, 2))
                0:       gap_limit = 0;
                1:       gap_limit = 2;
                default: gap_limit = 6;
            endcase
            if (!stack_filled && symbols_sent > SYMBOL_TARGET / 3) begin
                fill_stack();
                stack_filled = 1'b1;
            end
            phase_end = symbols_sent + $urandom_range(150, 350);
            while (symbols_sent < phase_end) begin
                send_string();
            end
        end
        drain_results();

        if (mismatch_count == 0 && segments_outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
